/* sv/assert_macros.svh */
// Assertion helper macros for the frame receiver.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/ibrc_pkg.sv */
// Shared types and constants for the RC frame receiver.
// No dependencies; used by every module of the block.
package ibrc_pkg;

  localparam logic       OP_BYTE     = 1'b0;
  localparam logic       OP_LINE_ERR = 1'b1;

  localparam logic [1:0] ST_GOOD     = 2'd0;
  localparam logic [1:0] ST_BAD      = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_LINE_ERR = 2'd3;

  localparam logic       CFG_MIN     = 1'b0;
  localparam logic       CFG_MAX     = 1'b1;

  localparam logic [7:0]  HDR_FIRST  = 8'h20;
  localparam logic [7:0]  HDR_SECOND = 8'h40;
  localparam logic [4:0]  POS_FIRST  = 5'd0;
  localparam logic [4:0]  POS_SECOND = 5'd1;
  localparam logic [4:0]  SUM_END    = 5'd30;
  localparam logic [4:0]  FRAME_LAST = 5'd31;
  localparam logic [15:0] CSUM_INIT  = 16'hFFFF;
  localparam logic [15:0] MIN_RESET  = 16'd800;
  localparam logic [15:0] MAX_RESET  = 16'd2200;

  typedef struct packed {
    logic       operation;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  channel_index;
    logic [15:0] channel_value;
    logic [31:0] frames_good;
    logic [31:0] errors_seen;
    logic        last;
  } out_item_t;

  // One queued event: a frame verdict or a line error, with counter snapshots.
  typedef struct packed {
    logic [1:0]  status;
    logic        bank;
    logic [31:0] frames_good;
    logic [31:0] errors_seen;
  } job_t;

  typedef struct packed {
    logic       bank;
    logic [3:0] idx;
  } rd_req_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } done_t;

endpackage

/* sv/ibrc_queue.sv */
// Two-entry job queue between the front and back parts.
// Depends on ibrc_pkg (job_t).
module ibrc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ibrc_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output ibrc_pkg::job_t pop_data
);

  ibrc_pkg::job_t mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign valid    = (count != 2'd0);
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* sv/ibrc_front.sv */
// Front part: byte intake, header hunt, running checksum and range check,
// channel word banks and counters. Depends on ibrc_pkg.
module ibrc_front #(
  parameter int CHANNELS = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  ibrc_pkg::in_item_t item,
  output logic              can_take,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              q_full,
  output logic              push,
  output ibrc_pkg::job_t    job,
  input  ibrc_pkg::rd_req_t rd,
  output logic [15:0]       rd_word,
  input  ibrc_pkg::done_t   done
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [15:0] channel_min;
  logic [15:0] channel_max;
  logic [4:0]  sync;
  logic [4:0]  sync_next;
  logic [15:0] sum;
  logic [15:0] sum_next;
  logic [7:0]  lo;
  logic [7:0]  lo_next;
  logic        range_bad;
  logic        range_bad_next;
  logic [31:0] frames;
  logic [31:0] frames_next;
  logic [31:0] errors;
  logic [31:0] errors_next;
  logic        wr_bank;
  logic        wr_bank_next;
  logic [1:0]  bank_busy;
  logic        wr_en;
  logic [3:0]  wr_idx;
  logic [15:0] word;
  logic [7:0]  b;

  logic [15:0] bank [2][CHANNELS];

  assign b        = item.byte_value;
  assign word     = {b, lo};
  assign wr_idx   = sync[4:1] - 4'd1;
  assign can_take = !q_full && !bank_busy[wr_bank];
  assign rd_word  = bank[rd.bank][rd.idx[IDX_W-1:0]];

  always_comb begin
    sync_next      = sync;
    sum_next       = sum;
    lo_next        = lo;
    range_bad_next = range_bad;
    frames_next    = frames;
    errors_next    = errors;
    wr_bank_next   = wr_bank;
    wr_en          = 1'b0;
    push           = 1'b0;
    job            = '0;
    if (accept) begin
      if (item.operation == ibrc_pkg::OP_LINE_ERR) begin
        sync_next   = ibrc_pkg::POS_FIRST;
        errors_next = errors + 32'd1;
        push        = 1'b1;
        job         = '{status: ibrc_pkg::ST_LINE_ERR, bank: 1'b0,
                        frames_good: frames, errors_seen: errors_next};
      end else if (sync == ibrc_pkg::POS_FIRST) begin
        if (b == ibrc_pkg::HDR_FIRST) begin
          sync_next      = ibrc_pkg::POS_SECOND;
          sum_next       = ibrc_pkg::CSUM_INIT - {8'h00, b};
          range_bad_next = 1'b0;
        end
      end else if (sync == ibrc_pkg::POS_SECOND) begin
        if (b == ibrc_pkg::HDR_SECOND) begin
          sync_next = sync + 5'd1;
          sum_next  = sum - {8'h00, b};
        end else if (b == ibrc_pkg::HDR_FIRST) begin
          // repeated first header: restart the frame here
          sync_next      = ibrc_pkg::POS_SECOND;
          sum_next       = ibrc_pkg::CSUM_INIT - {8'h00, b};
          range_bad_next = 1'b0;
        end else begin
          sync_next = ibrc_pkg::POS_FIRST;
        end
      end else begin
        if (sync < ibrc_pkg::SUM_END) begin
          sum_next = sum - {8'h00, b};
        end
        if (!sync[0]) begin
          lo_next = b;
        end else if (sync[4:1] <= 4'(CHANNELS)) begin
          // high byte of a channel word
          wr_en = 1'b1;
          if (word < channel_min || word > channel_max) begin
            range_bad_next = 1'b1;
          end
        end
        if (sync == ibrc_pkg::FRAME_LAST) begin
          sync_next = ibrc_pkg::POS_FIRST;
          push      = 1'b1;
          if (word != sum || range_bad) begin
            errors_next = errors + 32'd1;
            job = '{status: (word != sum) ? ibrc_pkg::ST_BAD : ibrc_pkg::ST_RANGE,
                    bank: wr_bank, frames_good: frames, errors_seen: errors_next};
          end else begin
            frames_next  = frames + 32'd1;
            wr_bank_next = ~wr_bank;
            job = '{status: ibrc_pkg::ST_GOOD, bank: wr_bank,
                    frames_good: frames_next, errors_seen: errors};
          end
        end else begin
          sync_next = sync + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bank[wr_bank][wr_idx[IDX_W-1:0]] <= word;
    end
    sum       <= sum_next;
    lo        <= lo_next;
    range_bad <= range_bad_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_min <= ibrc_pkg::MIN_RESET;
      channel_max <= ibrc_pkg::MAX_RESET;
      sync        <= ibrc_pkg::POS_FIRST;
      frames      <= '0;
      errors      <= '0;
      wr_bank     <= 1'b0;
      bank_busy   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ibrc_pkg::CFG_MIN: channel_min <= cfg_data;
          ibrc_pkg::CFG_MAX: channel_max <= cfg_data;
          default: ;
        endcase
      end
      sync    <= sync_next;
      frames  <= frames_next;
      errors  <= errors_next;
      wr_bank <= wr_bank_next;
      // a bank being released is never the one being filled
      if (done.valid) begin
        bank_busy[done.bank] <= 1'b0;
      end
      if (push && job.status == ibrc_pkg::ST_GOOD) begin
        bank_busy[job.bank] <= 1'b1;
      end
    end
  end

endmodule

/* sv/ibrc_back.sv */
// Back part: pops jobs and emits result items through an output register.
// Depends on ibrc_pkg.
module ibrc_back #(
  parameter int CHANNELS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  ibrc_pkg::job_t     q_data,
  output logic               pop,
  output ibrc_pkg::rd_req_t  rd,
  input  logic [15:0]        rd_word,
  output ibrc_pkg::done_t    done,
  output logic               res_valid,
  input  logic               res_ready,
  output ibrc_pkg::out_item_t res
);

  ibrc_pkg::job_t      cur;
  logic                cur_valid;
  logic [3:0]          idx;
  logic                advance;
  logic                cur_good;
  logic                cur_last;
  ibrc_pkg::out_item_t res_next;

  assign cur_good   = (cur.status == ibrc_pkg::ST_GOOD);
  assign cur_last   = !cur_good || (idx == 4'(CHANNELS - 1));
  assign advance    = cur_valid && (!res_valid || res_ready);
  assign pop        = q_valid && (!cur_valid || (advance && cur_last));
  assign rd         = '{bank: cur.bank, idx: idx};
  assign done.valid = advance && cur_last && cur_good;
  assign done.bank  = cur.bank;

  always_comb begin
    res_next.status        = cur.status;
    res_next.channel_index = cur_good ? idx : 4'd0;
    res_next.channel_value = cur_good ? rd_word : 16'd0;
    res_next.frames_good   = cur.frames_good;
    res_next.errors_seen   = cur.errors_seen;
    res_next.last          = cur_last;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
    if (pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      cur_valid <= 1'b0;
      idx       <= 4'd0;
    end else begin
      if (advance) begin
        res_valid <= 1'b1;
        idx       <= cur_last ? 4'd0 : idx + 4'd1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (pop) begin
        cur_valid <= 1'b1;
      end else if (advance && cur_last) begin
        cur_valid <= 1'b0;
      end
    end
  end

endmodule

/* sv/ibus_rc_frame_receiver_top.sv */
// Channel   | handshake                  | payload
// byte      | byte_valid / byte_ready    | byte_item   (ibrc_pkg::in_item_t)
// result    | result_valid / result_ready| result_item (ibrc_pkg::out_item_t)
// cfg       | cfg_we                     | cfg_index, cfg_data
//
// Bytes transfer at one per cycle; the front stalls only on a full job queue or
// when the channel bank it would fill is still being read out.
// A good frame yields CHANNELS results, one per cycle from the back part while
// result_ready is not stalling it; a bad frame or line error yields one.
// Jobs start back to back. Reset is synchronous; no clearing pass.
// Depends on ibrc_pkg, ibrc_front, ibrc_queue, ibrc_back, assert_macros.svh.
`include "assert_macros.svh"

module ibus_rc_frame_receiver_top #(
  parameter int CHANNELS = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  ibrc_pkg::in_item_t  byte_item,
  output logic                result_valid,
  input  logic                result_ready,
  output ibrc_pkg::out_item_t result_item,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);

  logic              accept;
  logic              q_full;
  logic              q_valid;
  logic              push;
  logic              pop;
  ibrc_pkg::job_t    job;
  ibrc_pkg::job_t    q_data;
  ibrc_pkg::rd_req_t rd;
  logic [15:0]       rd_word;
  ibrc_pkg::done_t   done;

  assign accept = byte_valid && byte_ready;

  ibrc_front #(.CHANNELS(CHANNELS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (byte_item),
    .can_take  (byte_ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .job       (job),
    .rd        (rd),
    .rd_word   (rd_word),
    .done      (done)
  );

  ibrc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (job),
    .full      (q_full),
    .pop       (pop),
    .valid     (q_valid),
    .pop_data  (q_data)
  );

  ibrc_back #(.CHANNELS(CHANNELS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .rd        (rd),
    .rd_word   (rd_word),
    .done      (done),
    .res_valid (result_valid),
    .res_ready (result_ready),
    .res       (result_item)
  );

  `ASSERT_IMP(a_no_push_full, clk, rst, push, !q_full || pop)
  `ASSERT_IMP(a_error_single, clk, rst,
    result_valid && result_item.status != ibrc_pkg::ST_GOOD,
    result_item.last && result_item.channel_index == 4'd0 &&
    result_item.channel_value == 16'd0)
  `ASSERT_IMP(a_good_last_idx, clk, rst,
    result_valid && result_item.status == ibrc_pkg::ST_GOOD && result_item.last,
    result_item.channel_index == 4'(CHANNELS - 1))
  `ASSERT_NXT(a_line_err_queued, clk, rst,
    accept && byte_item.operation == ibrc_pkg::OP_LINE_ERR, q_valid || u_back.cur_valid)

endmodule
